### hw/rtl/rv32eu_pkg.sv
// Shared types and constants for the RV32I subset execute unit.
// Command and status codes, access sizes, memory geometry.
// No dependencies.
package rv32eu_pkg;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned MEM_ROWS  = (MEM_BYTES + 3) / 4;
  localparam int unsigned ROW_AW    = $clog2(MEM_ROWS);
  // clearing pass covers every memory row and all 32 registers
  localparam int unsigned CLR_ROWS  = (MEM_ROWS > 32) ? MEM_ROWS : 32;
  localparam int unsigned CLR_AW    = $clog2(CLR_ROWS);

  // highest legal start address for each access size
  localparam logic [31:0] LIMIT_BYTE = 32'(MEM_BYTES - 1);
  localparam logic [31:0] LIMIT_HALF = 32'(MEM_BYTES - 2);
  localparam logic [31:0] LIMIT_WORD = 32'(MEM_BYTES - 4);

  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 112;

  typedef enum logic [3:0] {
    CMD_BEQ  = 4'd0,
    CMD_BNE  = 4'd1,
    CMD_BLT  = 4'd2,
    CMD_BGE  = 4'd3,
    CMD_SB   = 4'd4,
    CMD_SH   = 4'd5,
    CMD_SW   = 4'd6,
    CMD_ADDI = 4'd7,
    CMD_ADD  = 4'd8,
    CMD_SUB  = 4'd9,
    CMD_AND  = 4'd10,
    CMD_OR   = 4'd11,
    CMD_XOR  = 4'd12,
    CMD_LB   = 4'd13,
    CMD_LH   = 4'd14,
    CMD_LW   = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ILLEGAL = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  // access size in bytes
  typedef enum logic [2:0] {
    SIZE_BYTE = 3'd1,
    SIZE_HALF = 3'd2,
    SIZE_WORD = 3'd4
  } size_t;

endpackage

### hw/rtl/rv32i_subset_execute_unit.sv
// Execute unit for a subset of RV32I: register file, PC and byte data memory.
// Register file and data memory are synchronous RAMs inside this module.
// Depends on rv32eu_pkg.
//
//  channel | dir | handshake                   | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | s_axis_tdata[31:0]  instruction item
//  m_axis  | out | m_axis_tvalid/m_axis_tready | m_axis_tdata[111:0] result item
//
// One item per cycle while m_axis is not stalled; an accepted item passes register read,
// execute and load align / writeback before its result is valid on m_axis.
// After rst a clearing pass over max(MEM_BYTES/4, 32) rows (1024 here) zeroes both
// RAMs, one row of the four byte banks a cycle; s_axis_tready stays low meanwhile.
// A stalled output freezes the whole pipe; loads forward to the next item directly.
module rv32i_subset_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[3:0], dest_reg[8:4], src_reg_a[13:9], src_reg_b[18:14], immediate[31:19]
  input  logic [rv32eu_pkg::IN_W-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], next_pc[33:2], branch_taken[34], reg_written[35],
  // written_index[40:36], written_value[72:41], mem_address[104:73], zero[111:105]
  output logic [rv32eu_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned ROW_AW = rv32eu_pkg::ROW_AW;
  localparam int unsigned CLR_AW = rv32eu_pkg::CLR_AW;

  logic advance;
  logic s_fire;

  // clearing pass
  logic              clearing;
  logic [CLR_AW-1:0] clr_cnt;

  // execute stage
  logic                  e_valid;
  rv32eu_pkg::cmd_t      e_cmd;
  logic [4:0]            e_rd;
  logic [4:0]            e_ra;
  logic [4:0]            e_rb;
  logic [12:0]           e_imm;
  logic [31:0]           rf_a;
  logic [31:0]           rf_b;
  logic [31:0]           pc;

  logic [31:0]           op_a;
  logic [31:0]           op_b;
  logic [31:0]           imm_ext;
  logic [31:0]           addr;
  logic [31:0]           alu;
  logic [31:0]           limit;
  logic [31:0]           npc;
  logic                  is_branch;
  logic                  is_store;
  logic                  is_load;
  logic                  cond;
  logic                  oor;
  logic                  taken;
  logic                  wr;
  rv32eu_pkg::size_t     e_size;

  // load / writeback stage
  logic                  m_valid;
  rv32eu_pkg::status_t   m_status;
  logic [31:0]           m_npc;
  logic                  m_taken;
  logic                  m_wr;
  logic [4:0]            m_widx;
  logic [31:0]           m_alu;
  logic                  m_load;
  rv32eu_pkg::size_t     m_size;
  logic [1:0]            m_lo;
  logic [31:0]           m_maddr;
  logic [31:0]           ld_word;
  logic [31:0]           ld_val;
  logic [31:0]           m_value;

  // output register
  rv32eu_pkg::status_t   o_status;
  logic [31:0]           o_npc;
  logic                  o_taken;
  logic                  o_wr;
  logic [4:0]            o_widx;
  logic [31:0]           o_wval;
  logic [31:0]           o_maddr;

  // register file
  logic [31:0] rf [32];
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;

  // data memory bank read data
  logic [7:0]  bank_q [4];

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance && !clearing;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CLR_AW'(rv32eu_pkg::CLR_ROWS - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // ---------------- register file ----------------
  always_comb begin
    rf_we    = clearing || (advance && m_valid && m_wr);
    rf_waddr = clearing ? clr_cnt[4:0] : m_widx;
    rf_wdata = clearing ? 32'd0 : m_value;
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    if (s_fire) begin
      rf_a <= rf[s_axis_tdata[13:9]];
      rf_b <= rf[s_axis_tdata[18:14]];
    end
  end

  // ---------------- execute stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (advance) begin
      e_valid <= s_fire;
    end
    if (s_fire) begin
      e_cmd <= rv32eu_pkg::cmd_t'(s_axis_tdata[3:0]);
      e_rd  <= s_axis_tdata[8:4];
      e_ra  <= s_axis_tdata[13:9];
      e_rb  <= s_axis_tdata[18:14];
      e_imm <= s_axis_tdata[31:19];
    end
  end

  // forwarding: the item in writeback, then the write done at the read edge
  always_comb begin
    if (m_valid && m_wr && (m_widx == e_ra)) begin
      op_a = m_value;
    end else if (m_axis_tvalid && o_wr && (o_widx == e_ra)) begin
      op_a = o_wval;
    end else begin
      op_a = rf_a;
    end
    if (m_valid && m_wr && (m_widx == e_rb)) begin
      op_b = m_value;
    end else if (m_axis_tvalid && o_wr && (o_widx == e_rb)) begin
      op_b = o_wval;
    end else begin
      op_b = rf_b;
    end
  end

  always_comb begin
    imm_ext   = {{19{e_imm[12]}}, e_imm};
    addr      = op_a + imm_ext;
    alu       = addr;
    is_branch = 1'b0;
    is_store  = 1'b0;
    is_load   = 1'b0;
    cond      = 1'b0;
    e_size    = rv32eu_pkg::SIZE_WORD;
    unique case (e_cmd)
      rv32eu_pkg::CMD_BEQ: begin
        is_branch = 1'b1;
        cond      = (op_a == op_b);
      end
      rv32eu_pkg::CMD_BNE: begin
        is_branch = 1'b1;
        cond      = (op_a != op_b);
      end
      rv32eu_pkg::CMD_BLT: begin
        is_branch = 1'b1;
        cond      = ($signed(op_a) < $signed(op_b));
      end
      rv32eu_pkg::CMD_BGE: begin
        is_branch = 1'b1;
        cond      = ($signed(op_a) >= $signed(op_b));
      end
      rv32eu_pkg::CMD_SB: begin
        is_store = 1'b1;
        e_size   = rv32eu_pkg::SIZE_BYTE;
      end
      rv32eu_pkg::CMD_SH: begin
        is_store = 1'b1;
        e_size   = rv32eu_pkg::SIZE_HALF;
      end
      rv32eu_pkg::CMD_SW:   is_store = 1'b1;
      rv32eu_pkg::CMD_ADDI: alu = addr;
      rv32eu_pkg::CMD_ADD:  alu = op_a + op_b;
      rv32eu_pkg::CMD_SUB:  alu = op_a - op_b;
      rv32eu_pkg::CMD_AND:  alu = op_a & op_b;
      rv32eu_pkg::CMD_OR:   alu = op_a | op_b;
      rv32eu_pkg::CMD_XOR:  alu = op_a ^ op_b;
      rv32eu_pkg::CMD_LB: begin
        is_load = 1'b1;
        e_size  = rv32eu_pkg::SIZE_BYTE;
      end
      rv32eu_pkg::CMD_LH: begin
        is_load = 1'b1;
        e_size  = rv32eu_pkg::SIZE_HALF;
      end
      rv32eu_pkg::CMD_LW:   is_load = 1'b1;
      default: ;
    endcase

    unique case (e_size)
      rv32eu_pkg::SIZE_BYTE: limit = rv32eu_pkg::LIMIT_BYTE;
      rv32eu_pkg::SIZE_HALF: limit = rv32eu_pkg::LIMIT_HALF;
      default:               limit = rv32eu_pkg::LIMIT_WORD;
    endcase

    oor   = (is_store || is_load) && (addr > limit);
    taken = is_branch && cond;
    if (oor) begin
      npc = pc;
    end else if (taken) begin
      npc = pc + imm_ext;
    end else begin
      npc = pc + 32'd4;
    end
    wr = !is_branch && !is_store && !oor && (e_rd != 5'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (advance && e_valid) begin
      pc <= npc;
    end
  end

  // ---------------- data memory: four byte banks, bank = address[1:0] ----------------
  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0]        mem [rv32eu_pkg::MEM_ROWS];
    logic [1:0]        ofs;
    logic [ROW_AW-1:0] row;
    logic              we;
    logic [7:0]        wd;

    always_comb begin
      // byte of the access that lands in this bank
      ofs = 2'(g) - addr[1:0];
      row = clearing ? clr_cnt[ROW_AW-1:0]
                     : addr[ROW_AW+1:2] + ROW_AW'(2'(g) < addr[1:0]);
      we  = clearing
            || (advance && e_valid && is_store && !oor && ({1'b0, ofs} < e_size));
      wd  = clearing ? 8'd0 : op_b[8*ofs +: 8];
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[row] <= wd;
      end
      if (advance) begin
        bank_q[g] <= mem[row];
      end
    end
  end

  // ---------------- load align / writeback stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= e_valid;
    end
    if (advance) begin
      m_status <= oor ? rv32eu_pkg::STATUS_RANGE : rv32eu_pkg::STATUS_OK;
      m_npc    <= npc;
      m_taken  <= taken;
      m_wr     <= wr;
      m_widx   <= wr ? e_rd : 5'd0;
      m_alu    <= alu;
      m_load   <= is_load;
      m_size   <= e_size;
      m_lo     <= addr[1:0];
      m_maddr  <= (is_store || is_load) ? addr : 32'd0;
    end
  end

  always_comb begin
    ld_word = {bank_q[2'(m_lo + 2'd3)], bank_q[2'(m_lo + 2'd2)],
               bank_q[2'(m_lo + 2'd1)], bank_q[m_lo]};
    unique case (m_size)
      rv32eu_pkg::SIZE_BYTE: ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      rv32eu_pkg::SIZE_HALF: ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      default:               ld_val = ld_word;
    endcase
    m_value = m_load ? ld_val : m_alu;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= m_valid;
    end
    if (advance) begin
      o_status <= m_status;
      o_npc    <= m_npc;
      o_taken  <= m_taken;
      o_wr     <= m_wr;
      o_widx   <= m_widx;
      o_wval   <= m_wr ? m_value : 32'd0;
      o_maddr  <= m_maddr;
    end
  end

  assign m_axis_tdata = {7'd0, o_maddr, o_wval, o_widx, o_wr, o_taken, o_npc, o_status};

`ifndef ASSERT_OFF
  // writeback never targets x0
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    (advance && m_valid && m_wr) |-> (m_widx != 5'd0))
    else $error("register write to x0");

  // an out-of-range result carries no register write and no branch
  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (o_status == rv32eu_pkg::STATUS_RANGE)) |-> (!o_wr && !o_taken))
    else $error("out-of-range item changed state");

  // a frozen pipe keeps the program counter
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pc))
    else $error("pc moved during stall");

  // nothing enters while the clearing pass runs
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !e_valid)
    else $error("item accepted during clearing pass");
`endif

endmodule

### tb/sv/rv32i_subset_execute_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rv32i_subset_execute_unit: directed and random items.
// A scoreboard class predicts each result from its own model of the register file,
// PC and data memory. Depends on rv32eu_pkg and the execute unit RTL.
module rv32i_subset_execute_unit_tb;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 440;
  localparam int MAX_REPORTS     = 100;

  // field order matches s_axis_tdata, lowest bits last
  typedef struct packed {
    logic signed [12:0] imm;
    logic [4:0]         rb;
    logic [4:0]         ra;
    logic [4:0]         rd;
    rv32eu_pkg::cmd_t   cmd;
  } instr_t;

  typedef struct packed {
    logic [6:0]          pad;
    logic [31:0]         mem_address;
    logic [31:0]         written_value;
    logic [4:0]          written_index;
    logic                reg_written;
    logic                branch_taken;
    logic [31:0]         next_pc;
    rv32eu_pkg::status_t status;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0]  regs [32];
    logic [31:0]  pc;
    logic [7:0]   mem [rv32eu_pkg::MEM_BYTES];
    exec_result_t expected_q [$];
    int           errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
      errors = 0;
    endfunction

    static function int access_bytes(rv32eu_pkg::cmd_t c);
      case (c)
        rv32eu_pkg::CMD_SB, rv32eu_pkg::CMD_LB: return int'(rv32eu_pkg::SIZE_BYTE);
        rv32eu_pkg::CMD_SH, rv32eu_pkg::CMD_LH: return int'(rv32eu_pkg::SIZE_HALF);
        default:                                return int'(rv32eu_pkg::SIZE_WORD);
      endcase
    endfunction

    // every byte of the access must lie below MEM_BYTES; no wrap past 2^32
    static function bit fits(logic [31:0] addr, int nbytes);
      return ({1'b0, addr} + 33'(nbytes)) <= 33'(rv32eu_pkg::MEM_BYTES);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_instruction(instr_t ins);
      logic [31:0]  a, b, imm, addr, value;
      int           nbytes, i;
      bit           taken, ok;
      exec_result_t r;
      r = '0;
      imm = {{19{ins.imm[12]}}, ins.imm};
      a = (ins.ra == 5'd0) ? 32'd0 : regs[ins.ra];
      b = (ins.rb == 5'd0) ? 32'd0 : regs[ins.rb];
      addr = a + imm;
      r.next_pc = pc + 32'd4;
      ok = 1'b1;
      value = '0;
      case (ins.cmd)
        rv32eu_pkg::CMD_BEQ, rv32eu_pkg::CMD_BNE,
        rv32eu_pkg::CMD_BLT, rv32eu_pkg::CMD_BGE: begin
          case (ins.cmd)
            rv32eu_pkg::CMD_BEQ: taken = (a == b);
            rv32eu_pkg::CMD_BNE: taken = (a != b);
            rv32eu_pkg::CMD_BLT: taken = ($signed(a) < $signed(b));
            default:             taken = ($signed(a) >= $signed(b));
          endcase
          if (taken) begin
            r.branch_taken = 1'b1;
            r.next_pc = pc + imm;
          end
        end
        rv32eu_pkg::CMD_SB, rv32eu_pkg::CMD_SH, rv32eu_pkg::CMD_SW: begin
          nbytes = access_bytes(ins.cmd);
          r.mem_address = addr;
          ok = fits(addr, nbytes);
          if (ok)
            for (i = 0; i < nbytes; i++) mem[addr + i] = b[8*i +: 8];
        end
        rv32eu_pkg::CMD_LB, rv32eu_pkg::CMD_LH, rv32eu_pkg::CMD_LW: begin
          nbytes = access_bytes(ins.cmd);
          r.mem_address = addr;
          ok = fits(addr, nbytes);
          if (ok) begin
            for (i = 0; i < nbytes; i++) value[8*i +: 8] = mem[addr + i];
            if (nbytes == 1)
              value = {{24{value[7]}}, value[7:0]};
            else if (nbytes == 2)
              value = {{16{value[15]}}, value[15:0]};
          end
        end
        rv32eu_pkg::CMD_ADDI: value = a + imm;
        rv32eu_pkg::CMD_ADD:  value = a + b;
        rv32eu_pkg::CMD_SUB:  value = a - b;
        rv32eu_pkg::CMD_AND:  value = a & b;
        rv32eu_pkg::CMD_OR:   value = a | b;
        default:              value = a ^ b;
      endcase
      if (!ok) begin
        // out of range: nothing changes, PC holds
        r.status = rv32eu_pkg::STATUS_RANGE;
        r.next_pc = pc;
      end else begin
        if (ins.cmd >= rv32eu_pkg::CMD_ADDI && ins.rd != 5'd0) begin
          regs[ins.rd] = value;
          r.reg_written = 1'b1;
          r.written_index = ins.rd;
          r.written_value = value;
        end
        pc = r.next_pc;
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ERROR %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [rv32eu_pkg::OUT_W-1:0] raw);
      exec_result_t got, want;
      got = raw;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ERROR result item with none expected: expected none actual %h",
                   $time, raw);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("branch_taken", want.branch_taken, got.branch_taken);
      compare_field("reg_written", want.reg_written, got.reg_written);
      compare_field("written_index", want.written_index, got.written_index);
      compare_field("written_value", want.written_value, got.written_value);
      compare_field("mem_address", want.mem_address, got.mem_address);
      compare_field("padding", want.pad, got.pad);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [rv32eu_pkg::IN_W-1:0]  s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [rv32eu_pkg::OUT_W-1:0] m_axis_tdata;

  exec_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  rv32i_subset_execute_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // counts cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic instr_t mk(rv32eu_pkg::cmd_t c, int rd, int ra, int rb, int imm);
    instr_t ins;
    ins.cmd = c;
    ins.rd  = 5'(rd);
    ins.ra  = 5'(ra);
    ins.rb  = 5'(rb);
    ins.imm = 13'(imm);
    return ins;
  endfunction

  // mostly in-range memory traffic off x0, some of it in two small windows so
  // loads hit earlier stores; ADDI often off x0, branches sometimes with rb = ra; the rest is fully random
  function automatic instr_t random_instr();
    instr_t ins;
    int     pick;
    ins = instr_t'($urandom);
    pick = $urandom_range(99);
    case (ins.cmd)
      rv32eu_pkg::CMD_SB, rv32eu_pkg::CMD_SH, rv32eu_pkg::CMD_SW,
      rv32eu_pkg::CMD_LB, rv32eu_pkg::CMD_LH, rv32eu_pkg::CMD_LW: begin
        if (pick < 70) begin
          ins.ra = 5'd0;
          if (pick < 35)
            ins.imm = ($urandom_range(1) != 0) ? 13'($urandom_range(63))
                                               : 13'(4032 + $urandom_range(63));
          else
            ins.imm = 13'($urandom_range(4095));
        end
      end
      rv32eu_pkg::CMD_ADDI: if (pick < 50) ins.ra = 5'd0;
      rv32eu_pkg::CMD_BEQ, rv32eu_pkg::CMD_BNE,
      rv32eu_pkg::CMD_BLT, rv32eu_pkg::CMD_BGE: if (pick < 30) ins.rb = ins.ra;
      default: ;
    endcase
    return ins;
  endfunction

  task automatic send_item(instr_t ins);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ins;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_instruction(ins);
  endtask

  task automatic send_directed();
    send_item(mk(rv32eu_pkg::CMD_ADDI, 1, 0, 0, -1));
    send_item(mk(rv32eu_pkg::CMD_ADDI, 2, 0, 0, 4095));
    send_item(mk(rv32eu_pkg::CMD_ADDI, 3, 0, 0, -4096));
    send_item(mk(rv32eu_pkg::CMD_ADD, 4, 1, 2, 0));
    send_item(mk(rv32eu_pkg::CMD_SUB, 5, 0, 1, 0));
    send_item(mk(rv32eu_pkg::CMD_AND, 6, 1, 2, 0));
    send_item(mk(rv32eu_pkg::CMD_OR, 7, 3, 2, 0));
    send_item(mk(rv32eu_pkg::CMD_XOR, 8, 1, 3, 0));
    send_item(mk(rv32eu_pkg::CMD_ADDI, 0, 1, 0, 5));     // write to x0 is dropped
    send_item(mk(rv32eu_pkg::CMD_SW, 0, 0, 1, 4092));    // last whole word
    send_item(mk(rv32eu_pkg::CMD_SW, 0, 0, 1, 4093));    // straddles the top: out of range
    send_item(mk(rv32eu_pkg::CMD_SH, 0, 0, 3, 4094));
    send_item(mk(rv32eu_pkg::CMD_SB, 0, 2, 8, 0));       // byte 4095
    send_item(mk(rv32eu_pkg::CMD_SB, 0, 2, 8, 1));       // byte 4096: out of range
    send_item(mk(rv32eu_pkg::CMD_LW, 9, 0, 0, 4092));
    send_item(mk(rv32eu_pkg::CMD_LH, 10, 0, 0, 4094));
    send_item(mk(rv32eu_pkg::CMD_LB, 11, 2, 0, 0));
    send_item(mk(rv32eu_pkg::CMD_SW, 0, 0, 4, 1));       // unaligned store
    send_item(mk(rv32eu_pkg::CMD_LH, 12, 0, 0, 3));      // unaligned load
    send_item(mk(rv32eu_pkg::CMD_LB, 13, 1, 0, 0));      // 0xffffffff: out of range
    send_item(mk(rv32eu_pkg::CMD_LW, 14, 1, 0, 1));      // wraps to address 0
    send_item(mk(rv32eu_pkg::CMD_BEQ, 0, 1, 1, 4095));
    send_item(mk(rv32eu_pkg::CMD_BNE, 0, 0, 0, -4096));
    send_item(mk(rv32eu_pkg::CMD_BLT, 0, 1, 5, -4096));
    send_item(mk(rv32eu_pkg::CMD_BGE, 0, 1, 5, 8));
    send_item(mk(rv32eu_pkg::CMD_BGE, 0, 5, 1, 8));
    send_item(mk(rv32eu_pkg::CMD_BLT, 0, 5, 1, 8));
  endtask

  initial begin
    int phase, n;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 47; end
        default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
      endcase
      if (phase == 0) send_directed();
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_instr());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
